/* src/hdlc_frame_encoder_defines.svh */
// ----------------------------------------------------------------------------
// HDLC frame encoder assertion macros
// Shared property templates for the checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HDLC_FRAME_ENCODER_DEFINES_SVH
`define HDLC_FRAME_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/hdlc_pkg.sv */
// ----------------------------------------------------------------------------
// HDLC frame encoder package
// Chunk codes, controller/datapath interface types, bit stuffing and CRC
// functions shared by the encoder modules.
// ----------------------------------------------------------------------------
package hdlc_pkg;

    localparam logic [1:0]  KIND_FLAG = 2'd0;
    localparam logic [1:0]  KIND_HDR  = 2'd1;
    localparam logic [1:0]  KIND_DATA = 2'd2;
    localparam logic [1:0]  KIND_FCS  = 2'd3;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  HDR2_BYTE = 8'h03;
    localparam logic [7:0]  HDR3_BYTE = 8'hCC;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN = 3'd5;

    // Which chunk of a frame the datapath forms in this cycle.
    typedef enum logic [2:0] {
        STEP_FLAG = 3'd0,
        STEP_HDR0 = 3'd1,
        STEP_HDR1 = 3'd2,
        STEP_HDR2 = 3'd3,
        STEP_HDR3 = 3'd4,
        STEP_DATA = 3'd5,
        STEP_FCS0 = 3'd6,
        STEP_FCS1 = 3'd7
    } t_step;

    typedef struct packed {
        logic  load;         // latch the accepted payload byte
        logic  emit;         // form one chunk into the output register
        t_step step;
        logic  frame_start;  // opening flag of a frame: restart the CRC
        logic  last;         // final chunk of the current transaction
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;      // output register can take a chunk this cycle
    } t_dp_sts;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] len;
        logic [2:0] ones;
    } t_chunk;

    // Serializes one byte LSB first, inserting a zero after five ones.
    function automatic t_chunk stuff_byte(input logic [7:0] b, input logic [2:0] ones);
        t_chunk     c;
        logic [3:0] n;
        logic [2:0] run;
        c   = '0;
        n   = '0;
        run = ones;
        for (int i = 0; i < 8; i++) begin
            if (run >= STUFF_RUN) begin
                n   = n + 4'd1;
                run = '0;
            end
            c.bits[n] = b[i];
            n         = n + 4'd1;
            run       = b[i] ? (run + 3'd1) : 3'd0;
        end
        c.len  = n;
        c.ones = run;
        return c;
    endfunction

    // A flag never gets stuffed itself, but a pending stuff bit goes first.
    function automatic t_chunk flag_chunk(input logic [2:0] ones);
        t_chunk c;
        c = '0;
        if (ones == STUFF_RUN) begin
            c.bits = {1'b0, FLAG_BYTE, 1'b0};
            c.len  = 4'd9;
        end else begin
            c.bits = {2'b00, FLAG_BYTE};
            c.len  = 4'd8;
        end
        c.ones = '0;
        return c;
    endfunction

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if ((c[0] ^ b[i]) == 1'b1) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/hdlc_ctrl.sv */
// ----------------------------------------------------------------------------
// HDLC frame encoder controller
// Walks one transaction through flag, header, payload and FCS chunks and
// issues one chunk command per cycle while the output register has room.
// ----------------------------------------------------------------------------
module hdlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  hdlc_pkg::t_dp_sts i_sts,
    output hdlc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_FLAG = 9'b000000010,
        ST_HDR0 = 9'b000000100,
        ST_HDR1 = 9'b000001000,
        ST_HDR2 = 9'b000010000,
        ST_HDR3 = 9'b000100000,
        ST_DATA = 9'b001000000,
        ST_FCS0 = 9'b010000000,
        ST_FCS1 = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_func, n_func;
    logic   r_last, n_last;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state           = r_state;
        n_func            = r_func;
        n_last            = r_last;
        o_cmd             = '0;
        o_cmd.load        = accept;
        o_cmd.step        = hdlc_pkg::STEP_FLAG;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func  = i_func;
                    n_last  = i_last_byte;
                    n_state = (i_func || i_first_byte) ? ST_FLAG : ST_DATA;
                end
            end
            ST_FLAG: begin
                o_cmd.emit        = i_sts.out_free;
                o_cmd.step        = hdlc_pkg::STEP_FLAG;
                o_cmd.frame_start = !r_func;
                o_cmd.last        = r_func;
                if (i_sts.out_free) begin
                    n_state = r_func ? ST_IDLE : ST_HDR0;
                end
            end
            ST_HDR0: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_HDR0;
                if (i_sts.out_free) begin
                    n_state = ST_HDR1;
                end
            end
            ST_HDR1: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_HDR1;
                if (i_sts.out_free) begin
                    n_state = ST_HDR2;
                end
            end
            ST_HDR2: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_HDR2;
                if (i_sts.out_free) begin
                    n_state = ST_HDR3;
                end
            end
            ST_HDR3: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_HDR3;
                if (i_sts.out_free) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_DATA;
                o_cmd.last = !r_last;
                if (i_sts.out_free) begin
                    n_state = r_last ? ST_FCS0 : ST_IDLE;
                end
            end
            ST_FCS0: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_FCS0;
                if (i_sts.out_free) begin
                    n_state = ST_FCS1;
                end
            end
            ST_FCS1: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.step = hdlc_pkg::STEP_FCS1;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_func  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_last  <= n_last;
        end
    end

endmodule

/* src/hdlc_dp.sv */
// ----------------------------------------------------------------------------
// HDLC frame encoder datapath
// Holds the DLCI, payload byte, ones run and running CRC, forms one stuffed
// chunk per command and keeps it in the output register until it is taken.
// ----------------------------------------------------------------------------
module hdlc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_dlci_we,
    input  logic [9:0]        i_dlci,
    input  logic [7:0]        i_data_byte,
    input  hdlc_pkg::t_dp_cmd i_cmd,
    output hdlc_pkg::t_dp_sts o_sts,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [9:0]        o_chunk_bits,
    output logic [3:0]        o_chunk_len,
    output logic [1:0]        o_chunk_kind,
    output logic              o_last
);

    logic [9:0]       r_dlci;
    logic [7:0]       r_data;
    logic [2:0]       r_ones, n_ones;
    logic [15:0]      r_crc, n_crc;
    logic             r_valid, n_valid;
    logic [9:0]       r_bits;
    logic [3:0]       r_len;
    logic [1:0]       r_kind;
    logic             r_last;
    logic [7:0]       byte_sel;
    logic [1:0]       kind_sel;
    logic [15:0]      fcs;
    hdlc_pkg::t_chunk chunk;

    assign o_sts.out_free = !r_valid || i_ready;
    assign fcs            = ~r_crc;

    always_comb begin
        unique case (i_cmd.step)
            hdlc_pkg::STEP_FLAG: begin
                byte_sel = hdlc_pkg::FLAG_BYTE;
                kind_sel = hdlc_pkg::KIND_FLAG;
            end
            hdlc_pkg::STEP_HDR0: begin
                byte_sel = {r_dlci[9:4], 2'b00};
                kind_sel = hdlc_pkg::KIND_HDR;
            end
            hdlc_pkg::STEP_HDR1: begin
                byte_sel = {r_dlci[3:0], 4'b0000};
                kind_sel = hdlc_pkg::KIND_HDR;
            end
            hdlc_pkg::STEP_HDR2: begin
                byte_sel = hdlc_pkg::HDR2_BYTE;
                kind_sel = hdlc_pkg::KIND_HDR;
            end
            hdlc_pkg::STEP_HDR3: begin
                byte_sel = hdlc_pkg::HDR3_BYTE;
                kind_sel = hdlc_pkg::KIND_HDR;
            end
            hdlc_pkg::STEP_DATA: begin
                byte_sel = r_data;
                kind_sel = hdlc_pkg::KIND_DATA;
            end
            hdlc_pkg::STEP_FCS0: begin
                byte_sel = fcs[7:0];
                kind_sel = hdlc_pkg::KIND_FCS;
            end
            hdlc_pkg::STEP_FCS1: begin
                byte_sel = fcs[15:8];
                kind_sel = hdlc_pkg::KIND_FCS;
            end
            default: begin
                byte_sel = hdlc_pkg::FLAG_BYTE;
                kind_sel = hdlc_pkg::KIND_FLAG;
            end
        endcase

        if (i_cmd.step == hdlc_pkg::STEP_FLAG) begin
            chunk = hdlc_pkg::flag_chunk(r_ones);
        end else begin
            chunk = hdlc_pkg::stuff_byte(byte_sel, r_ones);
        end
    end

    always_comb begin
        n_ones  = r_ones;
        n_crc   = r_crc;
        n_valid = r_valid && !i_ready;
        if (i_cmd.emit) begin
            n_ones  = chunk.ones;
            n_valid = 1'b1;
            priority case (i_cmd.step)
                hdlc_pkg::STEP_FLAG: begin
                    if (i_cmd.frame_start) begin
                        n_crc = hdlc_pkg::CRC_INIT;
                    end
                end
                hdlc_pkg::STEP_FCS0: begin
                    n_crc = r_crc;
                end
                hdlc_pkg::STEP_FCS1: begin
                    n_crc = hdlc_pkg::CRC_INIT;
                end
                default: begin
                    // Header and payload bytes are covered by the frame check.
                    n_crc = hdlc_pkg::crc_byte(r_crc, byte_sel);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlci  <= '0;
            r_ones  <= '0;
            r_crc   <= hdlc_pkg::CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            if (i_dlci_we) begin
                r_dlci <= i_dlci;
            end
            r_ones  <= n_ones;
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.emit) begin
            r_bits <= chunk.bits;
            r_len  <= chunk.len;
            r_kind <= kind_sel;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_chunk_bits = r_bits;
    assign o_chunk_len  = r_len;
    assign o_chunk_kind = r_kind;
    assign o_last       = r_last;

endmodule

/* src/hdlc_frame_encoder.sv */
// ----------------------------------------------------------------------------
// HDLC frame encoder
// Frames payload bytes with flag, DLCI header, zero-bit stuffing and a
// CRC-16/X.25 frame check, producing one line chunk per output transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid/o_ready) carries one payload byte with first and
// last marks, or an idle request (i_func high) that asks for one flag.
// The output channel (o_valid/i_ready) carries chunks of up to ten line bits,
// bit 0 first; o_last marks the final chunk caused by an input transaction.
// An input yields 1 to 8 chunks: flag, four header bytes, the payload byte
// and two FCS bytes as the marks require. The controller forms one chunk per
// cycle into the output register while that register has room. An accepted
// input first sets the state register to its first chunk step, and that chunk
// is then registered in the output register. The sequencer handles one input
// at a time; the next input is taken while the final chunk still waits in the
// output register. When i_ready is low the output register holds its chunk and
// the sequencer waits. The DLCI is written through i_dlci_we/i_dlci while idle.
// Synchronous reset clears the DLCI, the ones run and the output valid, and
// sets the running CRC to all ones.
// ----------------------------------------------------------------------------
`include "hdlc_frame_encoder_defines.svh"

module hdlc_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_dlci_we,
    input  logic [9:0] i_dlci,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [9:0] o_chunk_bits,
    output logic [3:0] o_chunk_len,
    output logic [1:0] o_chunk_kind,
    output logic       o_last
);

    hdlc_pkg::t_dp_cmd cmd;
    hdlc_pkg::t_dp_sts sts;

    hdlc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    hdlc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dlci_we    (i_dlci_we),
        .i_dlci       (i_dlci),
        .i_data_byte  (i_data_byte),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_len  (o_chunk_len),
        .o_chunk_kind (o_chunk_kind),
        .o_last       (o_last)
    );

    // A flag chunk carries at most one leading stuff bit.
    `HFE_ASSERT_SAME(a_flag_len, o_valid && (o_chunk_kind == hdlc_pkg::KIND_FLAG), (o_chunk_len == 4'd8) || (o_chunk_len == 4'd9), "flag chunk has a bad length")

    // A stuffed byte is eight to ten bits long.
    `HFE_ASSERT_SAME(a_chunk_len, o_valid, (o_chunk_len >= 4'd8) && (o_chunk_len <= 4'd10), "chunk length out of range")

    // Line bits beyond the length of an eight-bit chunk stay zero.
    `HFE_ASSERT_SAME(a_bits_clean, o_valid && (o_chunk_len == 4'd8), o_chunk_bits[9:8] == 2'b00, "bits beyond chunk length are set")

    // Every accepted transaction produces at least one chunk before the next.
    `HFE_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "sequencer idle after acceptance")

endmodule

/* tb/sv/hdlc_frame_encoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC frame encoder testbench
// Drives payload bytes and idle requests into the encoder and predicts every
// line chunk. The prediction covers the flag, the DLCI header, zero-bit stuffing
// and the CRC-16/X.25 frame check. Received chunks are checked in order. Both
// channels are throttled at random, and the DLCI changes between test phases.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder_tb;

    localparam logic        FUNC_BYTE    = 1'b0;
    localparam logic        FUNC_IDLE    = 1'b1;
    localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
    localparam logic [7:0]  ADDR_CTRL    = 8'h03;
    localparam logic [7:0]  ADDR_TAIL    = 8'hCC;
    localparam logic [15:0] X25_POLY     = 16'h8408;
    localparam logic [15:0] X25_SEED     = 16'hFFFF;
    localparam logic [2:0]  STUFF_LIMIT  = 3'd5;
    localparam int          QUIET_CYCLES = 16;
    localparam int          TIMEOUT_NS   = 5_000_000;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] len;
        logic [1:0] kind;
        logic       last;
    } t_line_chunk;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_dlci_we;
    logic [9:0] i_dlci;
    logic       i_valid;
    logic       o_ready;
    logic       i_func;
    logic [7:0] i_data_byte;
    logic       i_first_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic [9:0] o_chunk_bits;
    logic [3:0] o_chunk_len;
    logic [1:0] o_chunk_kind;
    logic       o_last;

    // Predictor state, kept in step with the encoder.
    logic [9:0]  dlci_shadow = '0;
    logic [2:0]  run_len     = '0;
    logic [15:0] fcs_acc     = X25_SEED;

    t_line_chunk pending_chunks[$];
    t_line_chunk head_chunk;
    int          error_count = 0;

    // Sender burst pacing.
    int burst_left = 0;

    // Receiver stall pattern.
    int         sink_mode = 0;
    int         sink_hold = 0;
    logic [7:0] sink_phase = '0;

    hdlc_frame_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dlci_we    (i_dlci_we),
        .i_dlci       (i_dlci),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_len  (o_chunk_len),
        .o_chunk_kind (o_chunk_kind),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void fold_fcs(input logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            if (fcs_acc[0] ^ b[i]) begin
                fcs_acc = (fcs_acc >> 1) ^ X25_POLY;
            end else begin
                fcs_acc = fcs_acc >> 1;
            end
        end
    endfunction

    // A pending stuffed zero from the previous byte goes out ahead of the flag.
    function automatic t_line_chunk flag_line();
        t_line_chunk c;
        c      = '0;
        c.kind = hdlc_pkg::KIND_FLAG;
        if (run_len == STUFF_LIMIT) begin
            c.bits = {1'b0, FLAG_PATTERN, 1'b0};
            c.len  = 4'd9;
        end else begin
            c.bits = {2'b00, FLAG_PATTERN};
            c.len  = 4'd8;
        end
        run_len = '0;
        return c;
    endfunction

    function automatic t_line_chunk stuff_line_byte(input logic [7:0] b, input logic [1:0] kind);
        t_line_chunk c;
        int          pos;
        c      = '0;
        c.kind = kind;
        pos    = 0;
        for (int i = 0; i < 8; i++) begin
            if (run_len == STUFF_LIMIT) begin
                pos++;
                run_len = '0;
            end
            c.bits[pos] = b[i];
            pos++;
            run_len = b[i] ? run_len + 3'd1 : 3'd0;
        end
        c.len = 4'(pos);
        return c;
    endfunction

    function automatic t_line_chunk covered_line_byte(input logic [7:0] b,
                                                      input logic [1:0] kind);
        fold_fcs(b);
        return stuff_line_byte(b, kind);
    endfunction

    function automatic void predict_chunks(input logic func, input logic [7:0] data,
                                           input logic first, input logic lastb);
        t_line_chunk burst[$];
        logic [15:0] fcs;
        if (func == FUNC_IDLE) begin
            burst.push_back(flag_line());
        end else begin
            if (first) begin
                fcs_acc = X25_SEED;
                burst.push_back(flag_line());
                burst.push_back(covered_line_byte({dlci_shadow[9:4], 2'b00},
                                                  hdlc_pkg::KIND_HDR));
                burst.push_back(covered_line_byte({dlci_shadow[3:0], 4'h0},
                                                  hdlc_pkg::KIND_HDR));
                burst.push_back(covered_line_byte(ADDR_CTRL, hdlc_pkg::KIND_HDR));
                burst.push_back(covered_line_byte(ADDR_TAIL, hdlc_pkg::KIND_HDR));
            end
            burst.push_back(covered_line_byte(data, hdlc_pkg::KIND_DATA));
            if (lastb) begin
                fcs = ~fcs_acc;
                burst.push_back(stuff_line_byte(fcs[7:0], hdlc_pkg::KIND_FCS));
                burst.push_back(stuff_line_byte(fcs[15:8], hdlc_pkg::KIND_FCS));
                fcs_acc = X25_SEED;
            end
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) begin
            pending_chunks.push_back(burst[k]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chunks.size() == 0) begin
                $display("%0t: chunk with nothing expected, bits 0x%0h len %0d kind %0d last %b",
                         $time, o_chunk_bits, o_chunk_len, o_chunk_kind, o_last);
                error_count++;
            end else begin
                head_chunk = pending_chunks.pop_front();
                check_field("chunk_bits", 16'(head_chunk.bits), 16'(o_chunk_bits));
                check_field("chunk_len", 16'(head_chunk.len), 16'(o_chunk_len));
                check_field("chunk_kind", 16'(head_chunk.kind), 16'(o_chunk_kind));
                check_field("last", 16'(head_chunk.last), 16'(o_last));
            end
        end
    end

    // Receiver: the stall pattern is redrawn at random from four modes.
    always @(posedge i_clk) begin
        if (sink_hold == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_hold <= $urandom_range(20, 200);
        end else begin
            sink_hold <= sink_hold - 1;
        end
        sink_phase <= sink_phase + 8'd1;
        case (sink_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 99) < 70);
            end
            2: begin
                i_ready <= (sink_phase[2:0] < 3'd5);
            end
            default: begin
                i_ready <= ($urandom_range(0, 99) < 25);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(input logic func, input logic [7:0] data,
                             input logic first, input logic lastb);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_data_byte  <= data;
        i_first_byte <= first;
        i_last_byte  <= lastb;
        predict_chunks(func, data, first, lastb);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_for_quiet();
        i_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dlci(input logic [9:0] value);
        wait_for_quiet();
        i_dlci_we <= 1'b1;
        i_dlci    <= value;
        @(posedge i_clk);
        i_dlci_we   <= 1'b0;
        dlci_shadow  = value;
    endtask

    // Payload bytes lean toward long runs of ones so that stuffing is frequent.
    function automatic logic [7:0] pick_payload();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = 8'hFF;
            1: b = 8'hFF ^ (8'h01 << $urandom_range(0, 7));
            2: b = FLAG_PATTERN;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // The header of the first packet carries the DLCI value left by reset.
    task automatic test_reset_dlci_default();
        send_item(FUNC_BYTE, 8'hA5, 1'b1, 1'b0);
        send_item(FUNC_BYTE, 8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_dlci_extremes();
        logic [9:0] picks [4];
        picks = '{10'h3FF, 10'h000, 10'h2AA, 10'h155};
        foreach (picks[k]) begin
            write_dlci(picks[k]);
            send_item(FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    task automatic test_stuffing_extremes();
        write_dlci(10'h3FF);
        // Two all-ones bytes in a row give the ten-bit chunk.
        send_item(FUNC_BYTE, 8'hFF, 1'b1, 1'b0);
        send_item(FUNC_BYTE, 8'hFF, 1'b0, 1'b0);
        send_item(FUNC_BYTE, 8'h00, 1'b0, 1'b1);
        // The byte ends on five ones, so the next flag gets a leading zero.
        send_item(FUNC_BYTE, 8'hF8, 1'b1, 1'b0);
        send_item(FUNC_IDLE, 8'h00, 1'b0, 1'b0);
        // Same run, but the stuffed zero now opens the next payload byte.
        send_item(FUNC_BYTE, 8'hF8, 1'b0, 1'b0);
        send_item(FUNC_BYTE, 8'h01, 1'b0, 1'b1);
    endtask

    task automatic test_frame_special_cases();
        write_dlci(10'h0C3);
        // Payload with no open packet runs on the CRC as it stands.
        send_item(FUNC_BYTE, 8'h3C, 1'b0, 1'b0);
        // A first mark inside an open packet restarts the frame.
        send_item(FUNC_BYTE, 8'h81, 1'b1, 1'b0);
        send_item(FUNC_BYTE, 8'h55, 1'b1, 1'b1);
        // Idle ignores the payload fields.
        send_item(FUNC_IDLE, 8'hFF, 1'b1, 1'b1);
        // Idle inside a packet leaves the CRC alone.
        send_item(FUNC_BYTE, 8'h12, 1'b1, 1'b0);
        send_item(FUNC_IDLE, 8'h00, 1'b0, 1'b0);
        send_item(FUNC_BYTE, 8'h34, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int item_count, input logic [9:0] dlci_value);
        int sent;
        int pick;
        int pkt_len;
        write_dlci(dlci_value);
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6);
                for (int k = 0; k < pkt_len; k++) begin
                    if (k != 0 && $urandom_range(0, 19) == 0) begin
                        send_item(FUNC_IDLE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
                        sent++;
                    end
                    send_item(FUNC_BYTE, pick_payload(), k == 0, k == pkt_len - 1);
                end
                sent += pkt_len;
            end else if (pick < 88) begin
                send_item(FUNC_IDLE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                // Broken framing: marks and operation at random.
                send_item(1'($urandom_range(0, 1)), pick_payload(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_dlci_we    = 1'b0;
        i_dlci       = '0;
        i_valid      = 1'b0;
        i_func       = FUNC_BYTE;
        i_data_byte  = '0;
        i_first_byte = 1'b0;
        i_last_byte  = 1'b0;
        i_ready      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_dlci_default();
        test_dlci_extremes();
        test_stuffing_extremes();
        test_frame_special_cases();
        test_random_traffic(120, 10'($urandom_range(1, 1022)));
        test_random_traffic(120, 10'h3FF);
        test_random_traffic(120, 10'h000);
        test_random_traffic(120, 10'($urandom_range(0, 1023)));

        wait_for_quiet();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/hdlc_pkg.sv
src/hdlc_ctrl.sv
src/hdlc_dp.sv
src/hdlc_frame_encoder.sv
tb/sv/hdlc_frame_encoder_tb.sv
